/* hw/rtl/multi_slot_timer_scheduler_top_defines.svh */
// Assertion macros shared by the timer scheduler RTL.
// Every user module has ports i_clk and i_rst_n.
`ifndef MULTI_SLOT_TIMER_SCHEDULER_TOP_DEFINES_SVH
`define MULTI_SLOT_TIMER_SCHEDULER_TOP_DEFINES_SVH

// Checked only out of reset.
`define MST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/mst_sched_pkg.sv */
`timescale 1ns / 1ps

package mst_sched_pkg;

    localparam int OPCODE_W   = 2;
    localparam int SLOT_IDX_W = 4;
    localparam int INTERVAL_W = 32;

    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ARM  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_STOP = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [SLOT_IDX_W-1:0] slot;
        logic [INTERVAL_W-1:0] interval;
        logic                  rpt;
    } t_cmd;

endpackage

/* hw/rtl/mst_sched_ram.sv */
`timescale 1ns / 1ps

module mst_sched_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/mst_sched_front.sv */
`timescale 1ns / 1ps
`include "multi_slot_timer_scheduler_top_defines.svh"

module mst_sched_front #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    output logic                                       o_busy,
    input  logic [mst_sched_pkg::OPCODE_W-1:0]         i_opcode,
    input  logic [mst_sched_pkg::SLOT_IDX_W-1:0]       i_slot_index,
    input  logic [mst_sched_pkg::INTERVAL_W-1:0]       i_interval_ticks,
    input  logic                                       i_repeat_mode,
    output logic                                       o_q_vld,
    output mst_sched_pkg::t_cmd                        o_q_cmd,
    input  logic                                       i_pop
);

    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_count;
    mst_sched_pkg::t_cmd r_q [2];

    logic accept;
    logic useful;
    logic push;

    // Drop opcode 3 and slots beyond the table; they have no effect.
    always_comb begin
        useful = 1'b0;
        if (i_opcode == mst_sched_pkg::OP_TICK) begin
            useful = 1'b1;
        end else if (i_opcode == mst_sched_pkg::OP_ARM ||
                     i_opcode == mst_sched_pkg::OP_STOP) begin
            useful = (int'(i_slot_index) < TIMER_SLOTS);
        end
    end

    assign o_busy  = (r_count == 2'd2);
    assign accept  = i_start && !o_busy;
    assign push    = accept && useful;
    assign o_q_vld = (r_count != 2'd0);
    assign o_q_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{opcode:   i_opcode,
                           slot:     i_slot_index,
                           interval: i_interval_ticks,
                           rpt:      i_repeat_mode};
        end
    end

    `MST_ASSERT(a_pop_nonempty, i_pop |-> r_count != 2'd0, "pop from empty queue")
    `MST_ASSERT(a_count_max, r_count <= 2'd2, "queue count above depth")
    `MST_ASSERT(a_push_grows, (push && !i_pop) |=> r_count == $past(r_count) + 2'd1,
        "push lost")

endmodule

/* hw/rtl/mst_sched_back.sv */
`timescale 1ns / 1ps
`include "multi_slot_timer_scheduler_top_defines.svh"

module mst_sched_back #(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_vld,
    input  mst_sched_pkg::t_cmd                  i_q_cmd,
    output logic                                 o_pop,
    output logic                                 o_strobe,
    output logic [mst_sched_pkg::SLOT_IDX_W-1:0] o_fired_slot,
    output logic                                 o_last_of_tick
);

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int SX_W   = (SLOT_W > mst_sched_pkg::SLOT_IDX_W) ?
                            SLOT_W : mst_sched_pkg::SLOT_IDX_W;
    localparam int FS_W   = mst_sched_pkg::SLOT_IDX_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]             r_state,     n_state;
    logic [TIME_WIDTH-1:0]  r_time,      n_time;
    logic [TIMER_SLOTS-1:0] r_active,    n_active;
    logic [TIMER_SLOTS-1:0] r_repeats,   n_repeats;
    logic                   r_issue,     n_issue;
    logic [SLOT_W-1:0]      r_cnt,       n_cnt;
    logic                   r_s1_vld,    n_s1_vld;
    logic [SLOT_W-1:0]      r_s1_idx,    n_s1_idx;
    logic                   r_s1_last,   n_s1_last;
    logic                   r_pend_vld,  n_pend_vld;
    logic [FS_W-1:0]        r_pend_slot, n_pend_slot;
    logic                   r_out_vld,   n_out_vld;
    logic [FS_W-1:0]        r_out_slot,  n_out_slot;
    logic                   r_out_last,  n_out_last;

    logic [SX_W-1:0]       slot_ext;
    logic [SLOT_W-1:0]     cmd_idx;
    logic [TIME_WIDTH-1:0] ival_raw;
    logic [TIME_WIDTH-1:0] ival;
    logic                  hit;

    logic                  exp_we;
    logic [SLOT_W-1:0]     exp_waddr;
    logic [TIME_WIDTH-1:0] exp_wdata;
    logic [TIME_WIDTH-1:0] exp_rdata;
    logic                  per_we;
    logic [TIME_WIDTH-1:0] per_rdata;

    mst_sched_ram #(.WIDTH(TIME_WIDTH), .DEPTH(TIMER_SLOTS)) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (exp_we),
        .i_waddr (exp_waddr),
        .i_wdata (exp_wdata),
        .i_raddr (r_cnt),
        .o_rdata (exp_rdata)
    );

    mst_sched_ram #(.WIDTH(TIME_WIDTH), .DEPTH(TIMER_SLOTS)) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (per_we),
        .i_waddr (cmd_idx),
        .i_wdata (ival),
        .i_raddr (r_cnt),
        .o_rdata (per_rdata)
    );

    assign o_pop    = (r_state == ST_IDLE) && i_q_vld;
    assign slot_ext = SX_W'(i_q_cmd.slot);
    assign cmd_idx  = slot_ext[SLOT_W-1:0];
    assign ival_raw = TIME_WIDTH'(i_q_cmd.interval);
    assign ival     = (ival_raw == '0) ? TIME_WIDTH'(1) : ival_raw;
    assign hit      = r_s1_vld && r_active[r_s1_idx] && (exp_rdata == r_time);

    always_comb begin
        n_state     = r_state;
        n_time      = r_time;
        n_active    = r_active;
        n_repeats   = r_repeats;
        n_issue     = r_issue;
        n_cnt       = r_cnt;
        n_s1_vld    = 1'b0;
        n_s1_idx    = r_s1_idx;
        n_s1_last   = r_s1_last;
        n_pend_vld  = r_pend_vld;
        n_pend_slot = r_pend_slot;
        n_out_vld   = 1'b0;
        n_out_slot  = r_out_slot;
        n_out_last  = r_out_last;
        exp_we      = 1'b0;
        exp_waddr   = cmd_idx;
        exp_wdata   = r_time + ival;
        per_we      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    unique case (i_q_cmd.opcode)
                        mst_sched_pkg::OP_TICK: begin
                            n_time  = r_time + TIME_WIDTH'(1);
                            n_issue = 1'b1;
                            n_cnt   = '0;
                            n_state = ST_SCAN;
                        end
                        mst_sched_pkg::OP_ARM: begin
                            exp_we             = 1'b1;
                            per_we             = 1'b1;
                            n_active[cmd_idx]  = 1'b1;
                            n_repeats[cmd_idx] = i_q_cmd.rpt;
                        end
                        mst_sched_pkg::OP_STOP: begin
                            n_active[cmd_idx] = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue one slot read per cycle; the data lands in the cycle after.
                if (r_issue) begin
                    n_s1_vld  = 1'b1;
                    n_s1_idx  = r_cnt;
                    n_s1_last = (r_cnt == LAST_SLOT);
                    if (r_cnt == LAST_SLOT) begin
                        n_issue = 1'b0;
                    end else begin
                        n_cnt = r_cnt + SLOT_W'(1);
                    end
                end
                // Hold each firing until the next one shows it is not the last.
                if (hit) begin
                    if (r_pend_vld) begin
                        n_out_vld  = 1'b1;
                        n_out_slot = r_pend_slot;
                        n_out_last = 1'b0;
                    end
                    n_pend_vld  = 1'b1;
                    n_pend_slot = FS_W'(r_s1_idx);
                    if (r_repeats[r_s1_idx]) begin
                        exp_we    = 1'b1;
                        exp_waddr = r_s1_idx;
                        exp_wdata = exp_rdata + per_rdata;
                    end else begin
                        n_active[r_s1_idx] = 1'b0;
                    end
                end
                if (r_s1_vld && r_s1_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (r_pend_vld) begin
                    n_out_vld  = 1'b1;
                    n_out_slot = r_pend_slot;
                    n_out_last = 1'b1;
                end
                n_pend_vld = 1'b0;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_time     <= '0;
            r_active   <= '0;
            r_repeats  <= '0;
            r_issue    <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_time     <= n_time;
            r_active   <= n_active;
            r_repeats  <= n_repeats;
            r_issue    <= n_issue;
            r_s1_vld   <= n_s1_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_s1_idx    <= n_s1_idx;
        r_s1_last   <= n_s1_last;
        r_pend_slot <= n_pend_slot;
        r_out_slot  <= n_out_slot;
        r_out_last  <= n_out_last;
    end

    assign o_strobe       = r_out_vld;
    assign o_fired_slot   = r_out_slot;
    assign o_last_of_tick = r_out_last;

    `MST_ASSERT(a_last_ends_tick, (r_out_vld && r_out_last) |-> r_state == ST_IDLE,
        "last firing reported before tick finished")
    `MST_ASSERT(a_s1_in_scan, r_s1_vld |-> r_state == ST_SCAN, "slot compare outside scan")
    `MST_ASSERT(a_flush_clears, r_state == ST_FLUSH |=> !r_pend_vld,
        "pending firing kept past tick end")

endmodule

/* hw/rtl/multi_slot_timer_scheduler_top.sv */
`timescale 1ns / 1ps

// Timer slot scheduler. A word on start (taken when busy is low) ticks the
// time counter, arms a slot or stops a slot. Words go into a two-deep command
// queue; busy is high only while that queue is full. Arm and stop are applied
// as they are dequeued. A tick is dequeued, then the expiry and period
// memories are read one slot per cycle through their single read port, each
// read being registered, and then the tick is closed out. Each firing comes
// out for exactly one cycle on o_strobe with
// o_fired_slot, in ascending slot order; a firing is held until the next
// firing of the same tick or the end of the tick, so that the last firing of
// a tick can carry o_last_of_tick. The receiver cannot stall: it must take
// every strobed word. Expiry and period of a slot are undefined until armed.
module multi_slot_timer_scheduler_top #(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       start,
    output logic                                       busy,
    input  logic [mst_sched_pkg::OPCODE_W-1:0]         i_opcode,
    input  logic [mst_sched_pkg::SLOT_IDX_W-1:0]       i_slot_index,
    input  logic [mst_sched_pkg::INTERVAL_W-1:0]       i_interval_ticks,
    input  logic                                       i_repeat_mode,
    output logic                                       o_strobe,
    output logic [mst_sched_pkg::SLOT_IDX_W-1:0]       o_fired_slot,
    output logic                                       o_last_of_tick
);

    logic                q_vld;
    mst_sched_pkg::t_cmd q_cmd;
    logic                q_pop;

    mst_sched_front #(.TIMER_SLOTS(TIMER_SLOTS)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_opcode         (i_opcode),
        .i_slot_index     (i_slot_index),
        .i_interval_ticks (i_interval_ticks),
        .i_repeat_mode    (i_repeat_mode),
        .o_q_vld          (q_vld),
        .o_q_cmd          (q_cmd),
        .i_pop            (q_pop)
    );

    mst_sched_back #(.TIMER_SLOTS(TIMER_SLOTS), .TIME_WIDTH(TIME_WIDTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_vld        (q_vld),
        .i_q_cmd        (q_cmd),
        .o_pop          (q_pop),
        .o_strobe       (o_strobe),
        .o_fired_slot   (o_fired_slot),
        .o_last_of_tick (o_last_of_tick)
    );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS = 16;
    localparam logic [mst_sched_pkg::OPCODE_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [mst_sched_pkg::INTERVAL_W-1:0] ALL_ONES  = '1;

    typedef struct {
        mst_sched_pkg::t_cmd cmd;
        int unsigned         gap;
        bit                  drain;
    } t_sched_word;

    typedef struct {
        logic [mst_sched_pkg::SLOT_IDX_W-1:0] slot;
        logic                                 last;
    } t_firing;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic [mst_sched_pkg::OPCODE_W-1:0]   i_opcode = mst_sched_pkg::OP_TICK;
    logic [mst_sched_pkg::SLOT_IDX_W-1:0] i_slot_index = '0;
    logic [mst_sched_pkg::INTERVAL_W-1:0] i_interval_ticks = '0;
    logic                                 i_repeat_mode = 1'b0;
    logic                                 o_strobe;
    logic [mst_sched_pkg::SLOT_IDX_W-1:0] o_fired_slot;
    logic                                 o_last_of_tick;

    multi_slot_timer_scheduler_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_slot_index     (i_slot_index),
        .i_interval_ticks (i_interval_ticks),
        .i_repeat_mode    (i_repeat_mode),
        .o_strobe         (o_strobe),
        .o_fired_slot     (o_fired_slot),
        .o_last_of_tick   (o_last_of_tick)
    );

    // Timer state as the block should hold it
    logic [mst_sched_pkg::INTERVAL_W-1:0] now_ticks;
    logic [mst_sched_pkg::INTERVAL_W-1:0] slot_expiry [SLOTS];
    logic [mst_sched_pkg::INTERVAL_W-1:0] slot_period [SLOTS];
    bit                                   slot_repeats [SLOTS];
    bit                                   slot_live [SLOTS];

    t_sched_word pending_words [$];
    t_firing     due_firings [$];

    int unsigned idle_pct;
    bit          hold_next;
    int unsigned words_queued, words_taken;
    int unsigned ticks_taken, arms_taken, stops_taken, noise_taken;
    int unsigned firings_checked, busiest_tick, mismatches;

    t_sched_word next_word, live_word;
    bit          staged;
    int unsigned gap_left;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] ERROR: %s", $realtime, what);
        mismatches++;
    endtask

    // Apply one accepted word to the timer state and queue the firings it causes
    task automatic compute_firings(input t_sched_word w);
        t_firing                              f;
        int unsigned                          n;
        logic [mst_sched_pkg::INTERVAL_W-1:0] ivl;
        n = 0;
        case (w.cmd.opcode)
            mst_sched_pkg::OP_TICK: begin
                ticks_taken++;
                now_ticks = now_ticks + 1'b1;
                for (int s = 0; s < SLOTS; s++) begin
                    if (slot_live[s] && slot_expiry[s] == now_ticks) begin
                        f.slot = s[mst_sched_pkg::SLOT_IDX_W-1:0];
                        f.last = 1'b0;
                        due_firings = {due_firings, f};
                        n++;
                        if (slot_repeats[s])
                            slot_expiry[s] = slot_expiry[s] + slot_period[s];
                        else
                            slot_live[s] = 1'b0;
                    end
                end
                // mark the final firing of this tick
                if (n > 0)
                    due_firings[due_firings.size() - 1].last = 1'b1;
                if (n > busiest_tick)
                    busiest_tick = n;
            end
            mst_sched_pkg::OP_ARM: begin
                arms_taken++;
                ivl = (w.cmd.interval == '0) ? 1 : w.cmd.interval;
                slot_period[w.cmd.slot]  = ivl;
                slot_expiry[w.cmd.slot]  = now_ticks + ivl;
                slot_repeats[w.cmd.slot] = w.cmd.rpt;
                slot_live[w.cmd.slot]    = 1'b1;
            end
            mst_sched_pkg::OP_STOP: begin
                stops_taken++;
                slot_live[w.cmd.slot] = 1'b0;
            end
            default: noise_taken++;
        endcase
    endtask

    task automatic queue_word(input logic [mst_sched_pkg::OPCODE_W-1:0] op,
                              input int unsigned slot,
                              input logic [mst_sched_pkg::INTERVAL_W-1:0] ivl,
                              input logic rpt);
        t_sched_word w;
        w.cmd.opcode   = op;
        w.cmd.slot     = slot[mst_sched_pkg::SLOT_IDX_W-1:0];
        w.cmd.interval = ivl;
        w.cmd.rpt      = rpt;
        w.gap          = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
        w.drain        = hold_next;
        hold_next      = 1'b0;
        pending_words  = {pending_words, w};
        words_queued++;
    endtask

    // Driver: present one word at a time, hold it until busy lets it in
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                compute_firings(live_word);
                words_taken++;
            end
            if (!start || !busy) begin
                if (!staged && pending_words.size() > 0) begin
                    next_word = pending_words[0];
                    pending_words.delete(0);
                    staged    = 1'b1;
                    gap_left  = next_word.gap;
                end
                if (!staged) begin
                    start <= 1'b0;
                end else if (next_word.drain && due_firings.size() != 0) begin
                    start <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else begin
                    start            <= 1'b1;
                    i_opcode         <= next_word.cmd.opcode;
                    i_slot_index     <= next_word.cmd.slot;
                    i_interval_ticks <= next_word.cmd.interval;
                    i_repeat_mode    <= next_word.cmd.rpt;
                    live_word = next_word;
                    staged    = 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed word must match the oldest predicted firing
    always @(posedge i_clk) begin
        t_firing exp_f;
        if (i_rst_n && o_strobe) begin
            firings_checked++;
            if (due_firings.size() == 0) begin
                flag_mismatch($sformatf("firing of slot %0d with none predicted",
                                        o_fired_slot));
            end else begin
                exp_f = due_firings[0];
                due_firings.delete(0);
                if (o_fired_slot !== exp_f.slot)
                    flag_mismatch($sformatf("fired_slot %0d, predicted %0d",
                                            o_fired_slot, exp_f.slot));
                if (o_last_of_tick !== exp_f.last)
                    flag_mismatch($sformatf("last_of_tick %b on slot %0d, predicted %b",
                                            o_last_of_tick, exp_f.slot, exp_f.last));
            end
        end
    end

    initial begin
        int unsigned phase_idle [4];
        int unsigned phase_end, pick, n, v;

        phase_idle = '{0, 72, 0, 25};
        now_ticks = '0;
        for (int s = 0; s < SLOTS; s++) begin
            slot_repeats[s] = 1'b0;
            slot_live[s]    = 1'b0;
        end

        // directed: zero interval, repeat vs one-shot, stop, re-arm, ignored opcode
        idle_pct = 0;
        queue_word(mst_sched_pkg::OP_ARM, 0, '0, 1'b0);
        queue_word(mst_sched_pkg::OP_TICK, 0, '0, 1'b0);
        queue_word(mst_sched_pkg::OP_ARM, 15, 1, 1'b1);
        queue_word(mst_sched_pkg::OP_ARM, 3, 2, 1'b0);
        queue_word(mst_sched_pkg::OP_TICK, 7, ALL_ONES, 1'b1);
        queue_word(mst_sched_pkg::OP_TICK, 0, '0, 1'b0);
        queue_word(mst_sched_pkg::OP_STOP, 15, '0, 1'b0);
        queue_word(mst_sched_pkg::OP_TICK, 0, '0, 1'b0);
        queue_word(mst_sched_pkg::OP_STOP, 15, ALL_ONES, 1'b1);
        queue_word(OP_UNUSED, 7, ALL_ONES, 1'b1);
        queue_word(mst_sched_pkg::OP_ARM, 5, ALL_ONES, 1'b1);
        queue_word(mst_sched_pkg::OP_ARM, 5, 3, 1'b0);
        queue_word(mst_sched_pkg::OP_ARM, 9, 3, 1'b1);
        repeat (6) queue_word(mst_sched_pkg::OP_TICK, 0, '0, 1'b0);
        queue_word(mst_sched_pkg::OP_STOP, 9, '0, 1'b0);
        queue_word(mst_sched_pkg::OP_ARM, 10, 32'h8000_0000, 1'b0);
        queue_word(mst_sched_pkg::OP_STOP, 10, '0, 1'b0);

        for (int p = 0; p < 4; p++) begin
            idle_pct  = phase_idle[p];
            hold_next = (p > 0);
            phase_end = words_queued + 72;
            while (words_queued < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 50) begin
                    // arm a few slots with short intervals, then tick through them
                    n = $urandom_range(1, 4);
                    repeat (n) queue_word(mst_sched_pkg::OP_ARM, $urandom_range(15),
                                          $urandom_range(0, 12), 1'($urandom_range(1)));
                    repeat ($urandom_range(3, 14))
                        queue_word(mst_sched_pkg::OP_TICK, 0, '0, 1'b0);
                end else if (pick < 65) begin
                    queue_word(mst_sched_pkg::OP_STOP, $urandom_range(15), $urandom(),
                               1'($urandom_range(1)));
                    repeat ($urandom_range(0, 3))
                        queue_word(mst_sched_pkg::OP_TICK, 0, '0, 1'b0);
                end else if (pick < 75) begin
                    queue_word(mst_sched_pkg::OP_ARM, $urandom_range(15), $urandom(),
                               1'($urandom_range(1)));
                end else if (pick < 85) begin
                    queue_word(OP_UNUSED, $urandom_range(15), $urandom(),
                               1'($urandom_range(1)));
                    queue_word(mst_sched_pkg::OP_TICK, $urandom_range(15), $urandom(),
                               1'($urandom_range(1)));
                end else if (pick < 90) begin
                    // every slot due on the same ticks
                    v = $urandom_range(1, 3);
                    for (int s = 0; s < SLOTS; s++)
                        queue_word(mst_sched_pkg::OP_ARM, s, v, 1'b1);
                    repeat (4) queue_word(mst_sched_pkg::OP_TICK, 0, '0, 1'b0);
                    for (int s = 0; s < SLOTS; s++)
                        queue_word(mst_sched_pkg::OP_STOP, s, '0, 1'b0);
                end else begin
                    repeat ($urandom_range(1, 6))
                        queue_word(mst_sched_pkg::OP_TICK, 0, '0, 1'b0);
                end
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken != words_queued) @(posedge i_clk);
        while (due_firings.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Covered %0d words: %0d ticks, %0d arms, %0d stops, %0d unused opcodes.",
                 words_taken, ticks_taken, arms_taken, stops_taken, noise_taken);
        $display("Checked %0d firings, up to %0d on one tick; %0d errors.",
                 firings_checked, busiest_tick, mismatches);
        if (mismatches == 0)
            $display("multi_slot_timer_scheduler_top: match");
        else
            $display("multi_slot_timer_scheduler_top: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d of %0d words taken.", words_taken, words_queued);
        $display("multi_slot_timer_scheduler_top: mismatch");
        $finish;
    end

endmodule
